@@ rtl/assert_macros.svh @@
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clock, dropped while reset is high.
`define LBCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication form.
`define LBCT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/lbct_pkg.sv @@
package lbct_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int NumWidth  = 56;   // widest dividend: 40-bit sum magnitude << FracBits

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_REINIT,
      DP_ACC,
      DP_LAST,
      DP_DIV_CUR,
      DP_MUL_K,
      DP_SMOOTH,
      DP_MUL_DQ,
      DP_QRAW,
      DP_DIV_RAT,
      DP_MUL_E1,
      DP_ACC1,
      DP_MUL_R,
      DP_ACC2,
      DP_DIV_FRAC,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      logic div_done;
      logic bus_dead;
   } dp_status_type;

endpackage

@@ rtl/linear_battery_charge_tracker.sv @@
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  req_cmd, req_bus_voltage, req_load_power, req_last_load
// rsp       out  rsp_valid/rsp_ready  rsp_terminal_voltage, rsp_charge, rsp_charge_fraction,
//                                     rsp_empty_res, rsp_bus_dead
// csr       in   csr_valid/csr_ready  csr_index, csr_data
//
// A load or reinit word is applied as it is taken. A last load on a live bus runs three
// passes of the shared radix-2 divider (start, a shift per dividend bit, saturate, done)
// plus the multiply/accumulate steps; on a dead one it runs only the fraction pass.
// Reset is synchronous; charge reloads to the reset initial charge.
// A finished word waits in the output register; new words are taken while it waits,
// but the next result holds in the datapath, with the input stalled, until it frees.
module linear_battery_charge_tracker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [31:0] req_bus_voltage,
   input  logic signed [31:0] req_load_power,
   input  logic               req_last_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_terminal_voltage,
   output logic [30:0]        rsp_charge,
   output logic [30:0]        rsp_charge_fraction,
   output logic               rsp_empty_res,
   output logic               rsp_bus_dead,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import lbct_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   assign csr_ready = 1'b1;

   lbct_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_last_load (req_last_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .op            (op),
      .status        (status)
   );

   lbct_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .op                   (op),
      .status               (status),
      .req_bus_voltage      (req_bus_voltage),
      .req_load_power       (req_load_power),
      .rsp_terminal_voltage (rsp_terminal_voltage),
      .rsp_charge           (rsp_charge),
      .rsp_charge_fraction  (rsp_charge_fraction),
      .rsp_empty_res        (rsp_empty_res),
      .rsp_bus_dead         (rsp_bus_dead)
   );

endmodule

@@ rtl/lbct_div.sv @@
module lbct_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [lbct_pkg::NumWidth-1:0]        num,
   input  logic [lbct_pkg::DataWidth-1:0]       den,
   input  logic                                 neg,
   output logic                                 done,
   output logic signed [lbct_pkg::DataWidth-1:0] quo
);
   import lbct_pkg::*;

   localparam int CntWidth = $clog2(NumWidth);
   localparam logic [CntWidth-1:0] LastCnt = CntWidth'(NumWidth - 1);

   logic [NumWidth-1:0]  num_ff, num_in;
   logic [NumWidth-1:0]  quo_ff, quo_in;
   logic [DataWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0] den_ff;
   logic                 neg_ff;
   logic                 numz_ff;
   logic [CntWidth-1:0]  cnt_ff;
   logic                 busy_ff, fin_ff, done_ff;
   logic signed [DataWidth-1:0] res_ff;

   logic [DataWidth:0]   trial;
   logic                 ge;
   logic [DataWidth-1:0] lim, mag;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, num_ff[NumWidth-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DataWidth'(trial - {1'b0, den_ff}) : trial[DataWidth-1:0];
      quo_in = {quo_ff[NumWidth-2:0], ge};
      num_in = {num_ff[NumWidth-2:0], 1'b0};
      lim    = neg_ff ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
      mag    = (quo_ff > NumWidth'(lim)) ? lim : quo_ff[DataWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LastCnt) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
         if (fin_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         neg_ff  <= neg;
         numz_ff <= (num == '0);
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      // zero dividend gives zero, even over a zero divisor
      if (fin_ff) begin
         res_ff <= numz_ff ? '0 : (neg_ff ? $signed(-mag) : $signed(mag));
      end
   end

   assign done = done_ff;
   assign quo  = res_ff;

endmodule

@@ rtl/lbct_dp.sv @@
module lbct_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  lbct_pkg::dp_op_type     op,
   output lbct_pkg::dp_status_type status,
   input  logic signed [31:0]      req_bus_voltage,
   input  logic signed [31:0]      req_load_power,
   output logic signed [31:0]      rsp_terminal_voltage,
   output logic [30:0]             rsp_charge,
   output logic [30:0]             rsp_charge_fraction,
   output logic                    rsp_empty_res,
   output logic                    rsp_bus_dead
);
   import lbct_pkg::*;

   localparam logic [2:0] RegOcvConst  = 3'd0;
   localparam logic [2:0] RegOcvLinear = 3'd1;
   localparam logic [2:0] RegCapacity  = 3'd2;
   localparam logic [2:0] RegResist    = 3'd3;
   localparam logic [2:0] RegSmooth    = 3'd4;
   localparam logic [2:0] RegStep      = 3'd5;
   localparam logic [2:0] RegInitChg   = 3'd6;
   localparam logic [31:0] DeadMag     = 32'(((1 << FracBits) + 999) / 1000);

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
      else                            return v[31:0];
   endfunction

   // configuration
   logic signed [31:0] ocv_c_ff, ocv_l_ff;
   logic [30:0]        cap_ff, res_ff, ic_ff;
   logic [16:0]        k_ff;
   logic [31:0]        step_ff;

   // model state
   logic signed [39:0] psum_ff;
   logic signed [31:0] cur_ff;
   logic [30:0]        chg_ff;

   // step working registers
   logic signed [39:0] num_ff;
   logic signed [31:0] volt_ff;
   logic               dead_ff;
   logic [63:0]        prod_ff;
   logic               pneg_ff, psh32_ff;
   logic signed [33:0] qraw_ff, eacc_ff;
   logic signed [31:0] et_ff;
   logic               empty_ff;

   logic signed [31:0] rsp_tv_ff;
   logic [30:0]        rsp_chg_ff, rsp_frac_ff;
   logic               rsp_empty_ff, rsp_dead_ff;

   logic signed [40:0] sum_wide;
   logic signed [39:0] sum_in;
   logic [31:0]        vmag;
   logic signed [33:0] ma, mb;
   logic [33:0]        ma_abs, mb_abs;
   logic [47:0]        shifted;
   logic [31:0]        mlim, mmag;
   logic signed [31:0] msh;
   logic signed [33:0] et_diff;

   logic                div_start, div_done, div_neg;
   logic [NumWidth-1:0] div_num;
   logic [31:0]         div_den;
   logic signed [31:0]  div_quo;
   logic [39:0]         nmag;
   logic [33:0]         qmag;

   lbct_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .neg   (div_neg),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      sum_wide = 41'(psum_ff) + 41'(req_load_power);
      if (sum_wide > 41'sh0_7F_FFFF_FFFF)       sum_in = 40'sh7F_FFFF_FFFF;
      else if (sum_wide < -41'sh0_80_0000_0000) sum_in = 40'sh80_0000_0000;
      else                                      sum_in = sum_wide[39:0];
      vmag = volt_ff[31] ? 32'(-volt_ff) : 32'(volt_ff);

      // multiplier operand select
      case (op)
         DP_MUL_K: begin
            ma = $signed({17'b0, k_ff});
            mb = 34'(div_quo) - 34'(cur_ff);
         end
         DP_MUL_DQ: begin
            ma = 34'(cur_ff);
            mb = $signed({2'b0, step_ff});
         end
         DP_MUL_E1: begin
            ma = 34'(ocv_l_ff);
            mb = (34'sd1 <<< FracBits) - 34'(div_quo);
         end
         default: begin
            ma = $signed({3'b0, res_ff});
            mb = 34'(cur_ff);
         end
      endcase
      ma_abs = ma[33] ? 34'(-ma) : 34'(ma);
      mb_abs = mb[33] ? 34'(-mb) : 34'(mb);

      // truncate toward zero, saturate
      shifted = psh32_ff ? {16'b0, prod_ff[63:32]} : prod_ff[63:16];
      mlim    = pneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mmag    = (shifted > 48'(mlim)) ? mlim : shifted[31:0];
      msh     = pneg_ff ? $signed(-mmag) : $signed(mmag);
      et_diff = eacc_ff - 34'(msh);

      // divider operand select
      nmag = num_ff[39] ? 40'(-num_ff) : 40'(num_ff);
      qmag = qraw_ff[33] ? 34'(-qraw_ff) : 34'(qraw_ff);
      case (op)
         DP_DIV_CUR: begin
            div_num = NumWidth'(nmag) << FracBits;
            div_den = vmag;
            div_neg = num_ff[39] ^ volt_ff[31];
         end
         DP_DIV_RAT: begin
            div_num = NumWidth'(qmag) << FracBits;
            div_den = {1'b0, cap_ff};
            div_neg = qraw_ff[33];
         end
         default: begin
            div_num = NumWidth'(chg_ff) << FracBits;
            div_den = {1'b0, ic_ff};
            div_neg = 1'b0;
         end
      endcase
      div_start = (op == DP_DIV_CUR) || (op == DP_DIV_RAT) || (op == DP_DIV_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocv_c_ff <= '0;
         ocv_l_ff <= '0;
         cap_ff   <= 31'd65536;
         res_ff   <= '0;
         k_ff     <= '0;
         step_ff  <= '0;
         ic_ff    <= 31'd65536;
         psum_ff  <= '0;
         cur_ff   <= '0;
         chg_ff   <= 31'd65536;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               RegOcvConst:  ocv_c_ff <= csr_data;
               RegOcvLinear: ocv_l_ff <= csr_data;
               RegCapacity:  cap_ff   <= csr_data[30:0];
               RegResist:    res_ff   <= csr_data[30:0];
               RegSmooth:    k_ff     <= csr_data[16:0];
               RegStep:      step_ff  <= csr_data;
               RegInitChg:   ic_ff    <= csr_data[30:0];
               default: ;
            endcase
         end
         case (op)
            DP_REINIT: begin
               psum_ff <= '0;
               cur_ff  <= '0;
               chg_ff  <= ic_ff;
            end
            DP_ACC:    psum_ff <= sum_in;
            DP_LAST:   psum_ff <= '0;
            DP_SMOOTH: cur_ff  <= sat32(34'(cur_ff) + 34'(msh));
            DP_ACC2: begin
               if (qraw_ff <= 34'sd0)             chg_ff <= '0;
               else if (qraw_ff >= 34'(cap_ff))   chg_ff <= cap_ff;
               else                               chg_ff <= qraw_ff[30:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         DP_LAST: begin
            num_ff   <= sum_in;
            volt_ff  <= req_bus_voltage;
            dead_ff  <= ((req_bus_voltage[31] ? 32'(-req_bus_voltage)
                                               : 32'(req_bus_voltage)) < DeadMag);
            et_ff    <= '0;
            empty_ff <= 1'b0;
         end
         DP_MUL_K, DP_MUL_DQ, DP_MUL_E1, DP_MUL_R: begin
            prod_ff  <= ma_abs[31:0] * mb_abs[31:0];
            pneg_ff  <= ma[33] ^ mb[33];
            psh32_ff <= (op == DP_MUL_DQ);
         end
         DP_QRAW: qraw_ff <= $signed({3'b0, chg_ff}) - 34'(msh);
         DP_ACC1: eacc_ff <= 34'(ocv_c_ff) + 34'(msh);
         DP_ACC2: begin
            et_ff    <= sat32(et_diff);
            empty_ff <= (qraw_ff <= 34'sd0);
         end
         DP_OUT: begin
            rsp_tv_ff    <= et_ff;
            rsp_chg_ff   <= chg_ff;
            rsp_frac_ff  <= div_quo[30:0];
            rsp_empty_ff <= empty_ff;
            rsp_dead_ff  <= dead_ff;
         end
         default: ;
      endcase
   end

   assign status.div_done = div_done;
   assign status.bus_dead = dead_ff;

   assign rsp_terminal_voltage = rsp_tv_ff;
   assign rsp_charge           = rsp_chg_ff;
   assign rsp_charge_fraction  = rsp_frac_ff;
   assign rsp_empty_res        = rsp_empty_ff;
   assign rsp_bus_dead         = rsp_dead_ff;

endmodule

@@ rtl/lbct_ctrl.sv @@
module lbct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic                    req_last_load,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lbct_pkg::dp_op_type     op,
   input  lbct_pkg::dp_status_type status
);
   import lbct_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_CUR_GO, ST_CUR_WAIT, ST_K_MUL, ST_SMOOTH,
      ST_DQ_MUL, ST_QRAW, ST_RAT_GO, ST_RAT_WAIT, ST_E1_MUL, ST_ACC1,
      ST_R_MUL, ST_ACC2, ST_FRAC_GO, ST_FRAC_WAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_pending_ff;
   logic      out_load;

   // out_pending_ff: fraction done, word waits for the output register
   assign out_load = out_pending_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      op = DP_NOP;
      if (out_load) begin
         op = DP_OUT;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !out_pending_ff) begin
                  if (req_cmd)            op = DP_REINIT;
                  else if (req_last_load) op = DP_LAST;
                  else                    op = DP_ACC;
               end
            end
            ST_CUR_GO:  op = DP_DIV_CUR;
            ST_K_MUL:   op = DP_MUL_K;
            ST_SMOOTH:  op = DP_SMOOTH;
            ST_DQ_MUL:  op = DP_MUL_DQ;
            ST_QRAW:    op = DP_QRAW;
            ST_RAT_GO:  op = DP_DIV_RAT;
            ST_E1_MUL:  op = DP_MUL_E1;
            ST_ACC1:    op = DP_ACC1;
            ST_R_MUL:   op = DP_MUL_R;
            ST_ACC2:    op = DP_ACC2;
            ST_FRAC_GO: op = DP_DIV_FRAC;
            default:    op = DP_NOP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         out_pending_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff   <= 1'b1;
            out_pending_ff <= 1'b0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !out_pending_ff && !req_cmd && req_last_load)
                  state_ff <= ST_CHECK;
            end
            ST_CHECK:    state_ff <= status.bus_dead ? ST_FRAC_GO : ST_CUR_GO;
            ST_CUR_GO:   state_ff <= ST_CUR_WAIT;
            ST_CUR_WAIT: if (status.div_done) state_ff <= ST_K_MUL;
            ST_K_MUL:    state_ff <= ST_SMOOTH;
            ST_SMOOTH:   state_ff <= ST_DQ_MUL;
            ST_DQ_MUL:   state_ff <= ST_QRAW;
            ST_QRAW:     state_ff <= ST_RAT_GO;
            ST_RAT_GO:   state_ff <= ST_RAT_WAIT;
            ST_RAT_WAIT: if (status.div_done) state_ff <= ST_E1_MUL;
            ST_E1_MUL:   state_ff <= ST_ACC1;
            ST_ACC1:     state_ff <= ST_R_MUL;
            ST_R_MUL:    state_ff <= ST_ACC2;
            ST_ACC2:     state_ff <= ST_FRAC_GO;
            ST_FRAC_GO:  state_ff <= ST_FRAC_WAIT;
            ST_FRAC_WAIT: begin
               if (status.div_done) begin
                  out_pending_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !out_pending_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/lbct_checker.sv @@
`include "assert_macros.svh"

module lbct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_cmd,
   input logic               req_last_load,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_terminal_voltage,
   input logic [30:0]        rsp_charge,
   input logic               rsp_empty_res,
   input logic               rsp_bus_dead
);

   `LBCT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped")
   `LBCT_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_charge), "rsp word changed")
   `LBCT_ASSERT_IMP(a_dead_out, rsp_valid && rsp_bus_dead, rsp_terminal_voltage == 0 && !rsp_empty_res, "dead bus word not zeroed")
   `LBCT_ASSERT_IMP(a_empty_zero, rsp_valid && rsp_empty_res, rsp_charge == 0, "empty with charge left")
   `LBCT_ASSERT(a_busy_after_last, req_valid && req_ready && !req_cmd && req_last_load |=> !req_ready, "took word during step")

endmodule

bind linear_battery_charge_tracker lbct_checker u_lbct_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_cmd              (req_cmd),
   .req_last_load        (req_last_load),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_terminal_voltage (rsp_terminal_voltage),
   .rsp_charge           (rsp_charge),
   .rsp_empty_res        (rsp_empty_res),
   .rsp_bus_dead         (rsp_bus_dead)
);
